>>> sv/cne_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cne_pkg
// Shared types and codes for the cellular noise evaluator.
// ----------------------------------------------------------------------------
package cne_pkg;

  typedef enum logic [1:0] {
    OP_WRITE_POINT = 2'd0,
    OP_WRITE_PERM  = 2'd1,
    OP_EVAL        = 2'd2,
    OP_UNUSED      = 2'd3
  } op_t;

  // One request as it passes from the front end to the back end.
  typedef struct packed {
    op_t         op;
    logic [8:0]  entry_index;
    logic [15:0] point_x;
    logic [15:0] point_y;
    logic [7:0]  perm_value;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
  } req_t;

  // Number of feature points; the permutation table holds twice as many.
  // Table indexing relies on this being a power of two.
  localparam int TABLE_SIZE = 256;

  // Squared distance of 1.0 in Q.32.
  localparam logic [33:0] ONE_SQ = 34'h1_0000_0000;

endpackage
`default_nettype wire

>>> sv/cne_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cne_front
// Accepts requests, drops the unused op, and holds them in a short queue
// for the back end.
// ----------------------------------------------------------------------------
module cne_front (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  output logic             full,
  input  cne_pkg::req_t    req_in,
  output cne_pkg::req_t    req_out,
  output logic             req_valid,
  input  wire              req_take
);
  import cne_pkg::*;

  localparam int DEPTH = 4;

  req_t       q [DEPTH];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       do_push;
  logic       do_pop;

  assign full      = (count == 3'(DEPTH));
  assign do_push   = push && !full && (req_in.op != OP_UNUSED);
  assign req_valid = (count != 3'd0);
  assign do_pop    = req_valid && req_take;
  assign req_out   = q[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= req_in;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 2'd1;
      if (do_pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(do_push) - 3'(do_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= 3'(DEPTH)) else $error("front queue overflow");
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    do_pop |-> count != 3'd0) else $error("pop from empty queue");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> count == $past(count) + 3'd1)
    else $error("count did not advance");

endmodule
`default_nettype wire

>>> sv/cne_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cne_back
// Performs table writes and noise evaluation: nine neighbor cells visited
// one after another through the permutation and point tables, then a
// bit-serial square root, and a one-entry result register.
// ----------------------------------------------------------------------------
module cne_back #(
  parameter int FRAC_BITS  = 16
) (
  input  wire              clk,
  input  wire              rst,
  input  cne_pkg::req_t    req,
  input  wire              req_valid,
  output logic             req_take,
  output logic             empty,
  input  wire              pop,
  output logic [16:0]      noise_distance
);
  import cne_pkg::*;

  localparam int TW = $clog2(TABLE_SIZE);
  localparam int PW = TW + 1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PERMA = 7'b0000010,
    S_PERMB = 7'b0000100,
    S_POINT = 7'b0001000,
    S_DIST  = 7'b0010000,
    S_SQRT  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;

  logic [31:0] point_mem [TABLE_SIZE];
  logic [7:0]  perm_mem [2*TABLE_SIZE];
  logic [PW-1:0] perm_addr;
  logic [7:0]    perm_rd;
  logic [TW-1:0] point_addr;
  logic [31:0]   point_rd;

  logic signed [31:0] cx;
  logic signed [31:0] cy;
  logic [15:0] fx;
  logic [15:0] fy;
  logic [1:0]  ox;
  logic [1:0]  oy;
  logic [TW-1:0] hb;
  logic [33:0] best;
  logic signed [18:0] dx;
  logic signed [18:0] dy;
  logic [16:0] adx;
  logic [16:0] ady;
  logic [33:0] res;
  logic [33:0] rem;
  logic [4:0]  sq_step;
  logic        out_full;
  logic [16:0] out_reg;

  logic [31:0] pos_sel;

  // Split a position into cell and 16-bit fraction.
  function automatic logic signed [31:0] cell_of(input logic [31:0] p);
    cell_of = $signed(p) >>> FRAC_BITS;
  endfunction

  function automatic logic [15:0] frac_of(input logic [31:0] p);
    logic [31:0] f;
    f = p & ((32'd1 << FRAC_BITS) - 32'd1);
    if (FRAC_BITS >= 16) frac_of = 16'(f >> (FRAC_BITS - 16));
    else frac_of = 16'(f << (16 - FRAC_BITS));
  endfunction

  // Absolute value of cell plus offset, modulo the table size.
  function automatic logic [TW-1:0] hash_c(input logic signed [31:0] c,
                                           input logic [1:0] o);
    logic signed [33:0] s;
    logic [33:0] a;
    s = 34'(c) + 34'(signed'({1'b0, o})) - 34'sd1;
    a = s[33] ? 34'(-s) : 34'(s);
    hash_c = TW'(a % 34'(TABLE_SIZE));
  endfunction

  assign req_take = (state == S_IDLE) && req_valid;
  assign pos_sel  = req.pos_x;

  // Table writes share the port with reads; reads are registered.
  always_ff @(posedge clk) begin
    if (req_take && req.op == OP_WRITE_POINT && 32'(req.entry_index) < TABLE_SIZE) begin
      point_mem[TW'(req.entry_index)] <= {req.point_y, req.point_x};
    end
    point_rd <= point_mem[point_addr];
  end

  always_ff @(posedge clk) begin
    if (req_take && req.op == OP_WRITE_PERM && 32'(req.entry_index) < 2*TABLE_SIZE) begin
      perm_mem[PW'(req.entry_index)] <= req.perm_value;
    end
    perm_rd <= perm_mem[perm_addr];
  end

  // Read addresses for the current neighbor.
  always_comb begin
    perm_addr  = PW'(hash_c(cx, ox));
    point_addr = TW'(perm_rd);
    if (state == S_PERMB) begin
      perm_addr = PW'({1'b0, perm_rd} + {{(PW-TW){1'b0}}, hb});
    end
  end

  // Distance components for the fetched point.
  always_comb begin
    dx = 19'(signed'({3'b0, fx})) - (19'(signed'({1'b0, ox})) - 19'sd1) * 19'sd65536
         - 19'(signed'({3'b0, point_rd[15:0]}));
    dy = 19'(signed'({3'b0, fy})) - (19'(signed'({1'b0, oy})) - 19'sd1) * 19'sd65536
         - 19'(signed'({3'b0, point_rd[31:16]}));
  end

  // Squares are formed from magnitudes; the sum needs 35 bits.
  logic [34:0] d2;
  logic [33:0] trial;
  assign adx   = dx[18] ? 17'(-dx) : 17'(dx);
  assign ady   = dy[18] ? 17'(-dy) : 17'(dy);
  assign d2    = 35'({17'd0, adx} * {17'd0, adx}) + 35'({17'd0, ady} * {17'd0, ady});
  assign trial = res + (34'd1 << (2 * sq_step));

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_full <= 1'b0;
    end else begin
      if (state == S_OUT && (!out_full || pop)) out_full <= 1'b1;
      else if (pop && out_full) out_full <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req_take && req.op == OP_EVAL) begin
            cx    <= cell_of(pos_sel);
            cy    <= cell_of(req.pos_y);
            fx    <= frac_of(pos_sel);
            fy    <= frac_of(req.pos_y);
            ox    <= 2'd0;
            oy    <= 2'd0;
            best  <= ONE_SQ;
            state <= S_PERMA;
          end
        end
        S_PERMA: begin
          hb    <= hash_c(cy, oy);
          state <= S_PERMB;
        end
        S_PERMB: state <= S_POINT;
        S_POINT: state <= S_DIST;
        S_DIST: begin
          if (d2 < 35'(best)) best <= 34'(d2);
          if (oy == 2'd2) begin
            oy <= 2'd0;
            if (ox == 2'd2) begin
              res     <= '0;
              rem     <= (d2 < 35'(best)) ? 34'(d2) : best;
              sq_step <= 5'd16;
              state   <= S_SQRT;
            end else begin
              ox    <= ox + 2'd1;
              state <= S_PERMA;
            end
          end else begin
            oy    <= oy + 2'd1;
            state <= S_PERMA;
          end
        end
        S_SQRT: begin
          if (rem >= trial) begin
            rem <= rem - trial;
            res <= (res >> 1) + (34'd1 << (2 * sq_step));
          end else begin
            res <= res >> 1;
          end
          if (sq_step == 5'd0) state <= S_OUT;
          else sq_step <= sq_step - 5'd1;
        end
        S_OUT: begin
          // Wait here until the result register has room.
          if (!out_full || pop) begin
            out_reg <= res[16:0];
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign empty          = !out_full;
  assign noise_distance = out_reg;

  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    req_take |-> state == S_IDLE) else $error("request taken while busy");
  a_out_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_full && !pop) |=> state == S_OUT)
    else $error("result overwritten");
  a_best_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SQRT |-> rem <= ONE_SQ) else $error("distance above one");

endmodule
`default_nettype wire

>>> sv/cellular_noise_eval_2d.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cellular_noise_eval_2d
// Worley F1 cellular noise at a fixed-point 2-D position.
// ----------------------------------------------------------------------------
// Requests enter through push/full and results leave through empty/pop.
// Op 0 and op 1 load the feature-point and permutation tables and give no
// result; op 2 evaluates noise and gives one noise_distance; op 3 is dropped.
// A four-entry queue decouples acceptance from the evaluator.
// An evaluation visits the nine neighbor cells one after another, each with
// two dependent permutation reads and a point read through single-port
// tables, then the distance compare; it then runs the bit-serial square
// root and loads the result register. The back end performs a table write
// while idle and stays idle. It takes a new request only when idle, so a new
// evaluation starts only after the previous one has loaded its result.
// Reset empties the queue and the result register; table contents are not
// cleared and must be written before they are read.
// While the result is not popped, the back end finishes the next evaluation
// and holds it, the queue fills, and after that full stays high.
// ----------------------------------------------------------------------------
module cellular_noise_eval_2d #(
  parameter int FRAC_BITS  = 16
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               push,
  output logic              full,
  input  wire  [1:0]        op,
  input  wire  [8:0]        entry_index,
  input  wire  [15:0]       point_x,
  input  wire  [15:0]       point_y,
  input  wire  [7:0]        perm_value,
  input  wire  signed [31:0] pos_x,
  input  wire  signed [31:0] pos_y,
  output logic              empty,
  input  wire               pop,
  output logic [16:0]       noise_distance
);
  import cne_pkg::*;

  req_t req_in;
  req_t req_q;
  logic req_valid;
  logic req_take;

  assign req_in = '{op: op_t'(op), entry_index: entry_index, point_x: point_x,
                    point_y: point_y, perm_value: perm_value,
                    pos_x: pos_x, pos_y: pos_y};

  cne_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .req_in(req_in),
    .req_out(req_q), .req_valid(req_valid), .req_take(req_take)
  );

  cne_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .req(req_q), .req_valid(req_valid),
    .req_take(req_take), .empty(empty), .pop(pop),
    .noise_distance(noise_distance)
  );

endmodule
`default_nettype wire
